/* sv/ctc_pkg.sv */
// shared types, constants and helpers of the columnar transposition cipher
// no dependencies; imported by every module of the block
package ctc_pkg;

  localparam int MAX_KEY_DEF  = 16;
  localparam int MAX_TEXT_DEF = 32;

  localparam logic [7:0] UPPER_LO   = 8'd65;
  localparam logic [7:0] UPPER_HI   = 8'd90;
  localparam logic [7:0] KEY_SHIFT  = 8'd32;
  localparam logic [7:0] SPACE_BYTE = 8'd32;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE    = 2'd0,
    CFG_KEY_LEN = 2'd1,
    CFG_KEY_LO  = 2'd2,
    CFG_KEY_HI  = 2'd3
  } ctc_cfg_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } ctc_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       dropped;
  } ctc_out_t;

  // key byte normalization: uppercase letters kept, everything else shifted down
  function automatic logic [7:0] ctc_norm(input logic [7:0] b);
    logic [7:0] r;
    if (b >= UPPER_LO && b <= UPPER_HI) begin
      r = b;
    end else begin
      r = b - KEY_SHIFT;
    end
    return r;
  endfunction

endpackage

/* sv/ctc_msg_buffer.sv */
// message store with fill count and overflow flag
// depends on ctc_pkg
module ctc_msg_buffer import ctc_pkg::*; #(
  parameter int MAX_TEXT = MAX_TEXT_DEF,
  localparam int CW = $clog2(MAX_TEXT + 1),
  localparam int AW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [7:0]    wr_data_i,
  input  logic          clear_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o,
  output logic [CW-1:0] count_o,
  output logic          overflow_o
);

  logic [7:0]    mem [MAX_TEXT];
  logic [7:0]    rd_data_q;
  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic          has_room;

  assign has_room = (count_q < CW'(MAX_TEXT));

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (clear_i) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end else if (wr_en_i) begin
      if (has_room) begin
        count_d = count_q + CW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && has_room) begin
      mem[count_q[AW-1:0]] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign count_o    = count_q;
  assign overflow_o = ovf_q;

endmodule

/* sv/ctc_rank_unit.sv */
// column ranking: one shared byte comparator walks every pair of key columns
// depends on ctc_pkg (normalization helper)
module ctc_rank_unit import ctc_pkg::*; #(
  parameter int MAX_KEY = MAX_KEY_DEF,
  localparam int KW  = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1,
  localparam int KLW = $clog2(MAX_KEY + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [KLW-1:0] klen_i,
  input  logic [63:0]    key_lo_i,
  input  logic [63:0]    key_hi_i,
  output logic           done_o,
  output logic [KW-1:0]  rank_of_o [MAX_KEY],
  output logic [KW-1:0]  col_at_o [MAX_KEY]
);

  logic [7:0]    kb [MAX_KEY];
  logic [KW-1:0] c_q, j_q, rk_q;
  logic          busy_q, done_q;
  logic [KW-1:0] rank_of_q [MAX_KEY];
  logic [KW-1:0] col_at_q [MAX_KEY];
  logic [7:0]    vj, vc;
  logic          less;
  logic [KW-1:0] rk_sum;
  logic          j_end, c_end;

  always_comb begin
    for (int i = 0; i < MAX_KEY; i++) begin
      if (i < 8) begin
        kb[i] = key_lo_i[i*8 +: 8];
      end else begin
        kb[i] = key_hi_i[(i-8)*8 +: 8];
      end
    end
  end

  // ties go to the lower column position
  assign vj     = ctc_norm(kb[j_q]);
  assign vc     = ctc_norm(kb[c_q]);
  assign less   = (vj < vc) || ((vj == vc) && (j_q < c_q));
  assign rk_sum = rk_q + KW'(less);
  assign j_end  = (KLW'(j_q) + KLW'(1)) == klen_i;
  assign c_end  = (KLW'(c_q) + KLW'(1)) == klen_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      c_q    <= '0;
      j_q    <= '0;
      rk_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        c_q    <= '0;
        j_q    <= '0;
        rk_q   <= '0;
      end else if (busy_q) begin
        if (j_end) begin
          j_q  <= '0;
          rk_q <= '0;
          if (c_end) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            c_q <= c_q + KW'(1);
          end
        end else begin
          j_q  <= j_q + KW'(1);
          rk_q <= rk_sum;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !start_i && j_end) begin
      rank_of_q[c_q]  <= rk_sum;
      col_at_q[rk_sum] <= c_q;
    end
  end

  assign done_o    = done_q;
  assign rank_of_o = rank_of_q;
  assign col_at_o  = col_at_q;

endmodule

/* sv/columnar_transposition_cipher_core.sv */
// columnar transposition cipher: buffers a message, then emits it transposed
// usage:
//   input channel (in_valid_i / in_stall_o) takes one message word per cycle
//   while loading; a word with final_byte set closes the message. words past
//   the buffer are dropped and the dropped flag is set on every output word.
//   after the final word the block stalls its input: it counts the rows,
//   ranks the key columns with one comparator, then emits rows * key_length
//   words, each passing through address multiply, buffer read and output hold.
//   out_last marks the last word. a stall from the receiver holds the output
//   word and freezes the sequencer. once the last word is taken the buffer is
//   emptied and loading resumes.
//   configuration words (cfg_valid_i / cfg_ready_o) are always taken and
//   should only be sent while the block is idle. reset empties the buffer,
//   sets encrypt mode and key length 1; no clearing pass is needed.
// depends on ctc_pkg, ctc_msg_buffer, ctc_rank_unit
module columnar_transposition_cipher_core import ctc_pkg::*; #(
  parameter int MAX_KEY  = MAX_KEY_DEF,
  parameter int MAX_TEXT = MAX_TEXT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ctc_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ctc_out_t              out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int KW  = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
  localparam int KLW = $clog2(MAX_KEY + 1);
  localparam int CW  = $clog2(MAX_TEXT + 1);
  localparam int AW  = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
  localparam int PW  = $clog2(MAX_TEXT + MAX_KEY);
  localparam int OW  = (CW > KLW) ? CW : KLW;

  typedef enum logic [5:0] {
    S_LOAD = 6'b000001,
    S_ROWS = 6'b000010,
    S_RANK = 6'b000100,
    S_ADDR = 6'b001000,
    S_READ = 6'b010000,
    S_SEND = 6'b100000
  } ctc_state_e;

  ctc_state_e state_q, state_d;

  logic          mode_q;
  logic [4:0]    key_len_q;
  logic [63:0]   key_lo_q, key_hi_q;
  logic [KLW-1:0] klen;

  logic          in_acc;
  logic [7:0]    rd_data;
  logic [CW-1:0] count;
  logic          overflow;
  logic          buf_clear;

  logic          rank_start, rank_done;
  logic [KW-1:0] rank_of [MAX_KEY];
  logic [KW-1:0] col_at [MAX_KEY];

  logic [PW-1:0] acc_q;
  logic [CW-1:0] rows_q;
  logic [OW-1:0] outer_q, inner_q;
  logic [PW-1:0] pos_q, pos_d;
  logic          inrange_q;
  logic          enc;
  logic [PW-1:0] mul_a, mul_b, add_c;
  logic          outer_last, inner_last, rows_done;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_ENCRYPT;
      key_len_q <= 5'd1;
      key_lo_q  <= '0;
      key_hi_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (ctc_cfg_e'(cfg_index_i))
        CFG_MODE:    mode_q    <= cfg_data_i[0];
        CFG_KEY_LEN: key_len_q <= cfg_data_i[4:0];
        CFG_KEY_LO:  key_lo_q  <= cfg_data_i;
        CFG_KEY_HI:  key_hi_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero counts as one column, oversize saturates
  always_comb begin
    if (key_len_q == 5'd0) begin
      klen = KLW'(1);
    end else if (32'(key_len_q) > MAX_KEY) begin
      klen = KLW'(MAX_KEY);
    end else begin
      klen = KLW'(key_len_q);
    end
  end

  assign in_stall_o = (state_q != S_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign enc        = (mode_q == MODE_ENCRYPT);

  assign rows_done  = (acc_q >= PW'(count));
  assign rank_start = (state_q == S_ROWS) && rows_done;

  ctc_msg_buffer #(
    .MAX_TEXT(MAX_TEXT)
  ) u_buffer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (in_acc),
    .wr_data_i  (in_data_i.text_byte),
    .clear_i    (buf_clear),
    .rd_en_i    ((state_q == S_READ) && inrange_q),
    .rd_addr_i  (pos_q[AW-1:0]),
    .rd_data_o  (rd_data),
    .count_o    (count),
    .overflow_o (overflow)
  );

  ctc_rank_unit #(
    .MAX_KEY(MAX_KEY)
  ) u_rank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (rank_start),
    .klen_i    (klen),
    .key_lo_i  (key_lo_q),
    .key_hi_i  (key_hi_q),
    .done_o    (rank_done),
    .rank_of_o (rank_of),
    .col_at_o  (col_at)
  );

  // encrypt walks columns in rank order then rows; decrypt walks rows then columns
  assign outer_last = enc ? (outer_q == OW'(klen - KLW'(1)))
                          : (outer_q == OW'(rows_q - CW'(1)));
  assign inner_last = enc ? (inner_q == OW'(rows_q - CW'(1)))
                          : (inner_q == OW'(klen - KLW'(1)));

  always_comb begin
    if (enc) begin
      mul_a = PW'(inner_q);
      mul_b = PW'(klen);
      add_c = PW'(col_at[outer_q[KW-1:0]]);
    end else begin
      mul_a = PW'(rank_of[inner_q[KW-1:0]]);
      mul_b = PW'(rows_q);
      add_c = PW'(outer_q);
    end
    pos_d = PW'(mul_a * mul_b) + add_c;
  end

  assign buf_clear = (state_q == S_SEND) && !out_stall_i && inner_last && outer_last;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD: if (in_acc && in_data_i.final_byte) state_d = S_ROWS;
      S_ROWS: if (rows_done) state_d = S_RANK;
      S_RANK: if (rank_done) state_d = S_ADDR;
      S_ADDR: state_d = S_READ;
      S_READ: state_d = S_SEND;
      S_SEND: begin
        if (!out_stall_i) begin
          state_d = buf_clear ? S_LOAD : S_ADDR;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      acc_q   <= '0;
      rows_q  <= '0;
      outer_q <= '0;
      inner_q <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_LOAD: begin
          acc_q  <= '0;
          rows_q <= '0;
        end
        S_ROWS: begin
          if (!rows_done) begin
            acc_q  <= acc_q + PW'(klen);
            rows_q <= rows_q + CW'(1);
          end
        end
        S_RANK: begin
          outer_q <= '0;
          inner_q <= '0;
        end
        S_SEND: begin
          if (!out_stall_i) begin
            if (inner_last) begin
              inner_q <= '0;
              outer_q <= outer_q + OW'(1);
            end else begin
              inner_q <= inner_q + OW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_ADDR) begin
      pos_q     <= pos_d;
      inrange_q <= (pos_d < PW'(count));
    end
  end

  assign out_valid_o         = (state_q == S_SEND);
  assign out_data_o.out_byte = inrange_q ? rd_data : SPACE_BYTE;
  assign out_data_o.out_last = inner_last && outer_last;
  assign out_data_o.dropped  = overflow;

endmodule
